// File: rtl/rmbt_pkg.sv
// Shared types, codes and defaults for the region mask bounding box tracker.
`timescale 1ns / 1ps

package rmbt_pkg;

    localparam int DEF_IMAGE_WIDTH  = 256;
    localparam int DEF_IMAGE_HEIGHT = 256;

    localparam int COORD_W   = 8;
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_COL_START,
        ST_ROW_START,
        ST_SCAN,
        ST_FETCH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic src_we;
        logic mem_we;
        logic wr_bit;
    } map_req_t;

endpackage

// File: rtl/rmbt_pixel_maps.sv
// Source and membership bit maps with one shared port and a clearing pass after reset.
`timescale 1ns / 1ps

module rmbt_pixel_maps
    import rmbt_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  map_req_t req,
    input  coord_t   col,
    input  coord_t   row,
    output logic     ready,
    output logic     rd_member,
    output logic     rd_source
);

    localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic          member_mem [DEPTH];
    logic          source_mem [DEPTH];
    logic [AW-1:0] addr;
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_busy_reg;
    logic          rd_member_reg;
    logic          rd_source_reg;

    assign addr      = AW'({24'd0, row} * 32'(IMAGE_WIDTH) + {24'd0, col});
    assign ready     = ~clr_busy_reg;
    assign rd_member = rd_member_reg;
    assign rd_source = rd_source_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            member_mem[clr_cnt_reg] <= 1'b0;
            source_mem[clr_cnt_reg] <= 1'b0;
        end else begin
            if (req.mem_we) begin
                member_mem[addr] <= req.wr_bit;
            end
            if (req.src_we) begin
                source_mem[addr] <= req.wr_bit;
            end
        end
        if (req.rd_en) begin
            rd_member_reg <= member_mem[addr];
            rd_source_reg <= source_mem[addr];
        end
    end

endmodule

// File: rtl/region_mask_bounding_box_tracker.sv
// Top level of the region mask bounding box tracker with its request sequencer.
//
//  Channel  Direction  Payload
//  s_       in         tuser: req_type; tdata: pixel_x, pixel_y, source_value
//  m_       out        tdata: box_left, box_right, box_top, box_bottom, region_empty,
//                             masked_pixel
//
// After reset the maps are cleared one pixel per cycle, all IMAGE_WIDTH * IMAGE_HEIGHT pixels,
// and s_tready stays low meanwhile.
// Writes, adds and requests off the image go from acceptance through ST_EXEC, ST_FETCH and ST_RESULT.
// A remove on a box edge rescans the box inward from that edge through the single map read
// port, one pixel per cycle, until it finds a lit member pixel or has read the whole box.
// A new transaction is taken only once the previous result has been taken.
`timescale 1ns / 1ps

module region_mask_bounding_box_tracker
    import rmbt_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] pixel_x, [15:8] pixel_y, [16] source_value, [23:17] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] box_left, [15:8] box_right, [23:16] box_top, [31:24] box_bottom,
    // [32] region_empty, [33] masked_pixel, [39:34] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    state_t   state_reg, state_next;
    req_t     req_reg, req_next;
    coord_t   x_reg, x_next;
    coord_t   y_reg, y_next;
    logic     val_reg, val_next;
    logic     inside_reg, inside_next;

    coord_t   left_reg, left_next;
    coord_t   right_reg, right_next;
    coord_t   top_reg, top_next;
    coord_t   bottom_reg, bottom_next;
    logic     empty_reg, empty_next;

    logic     col_phase_reg, col_phase_next;
    logic     from_low_reg, from_low_next;
    coord_t   out_lo_reg, out_lo_next;
    coord_t   out_hi_reg, out_hi_next;
    coord_t   in_lo_reg, in_lo_next;
    coord_t   in_hi_reg, in_hi_next;
    coord_t   outer_reg, outer_next;
    coord_t   inner_reg, inner_next;
    logic     issuing_reg, issuing_next;
    logic     pend_reg, pend_next;
    coord_t   pend_outer_reg, pend_outer_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    map_req_t map_req;
    coord_t   map_col;
    coord_t   map_row;
    logic     map_ready;
    logic     rd_member;
    logic     rd_source;

    logic     hit;
    logic     outer_last;
    logic     row_hit_edge;
    coord_t   in_x;
    coord_t   in_y;

    rmbt_pixel_maps #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .IMAGE_HEIGHT(IMAGE_HEIGHT)
    ) u_maps (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (map_req),
        .col      (map_col),
        .row      (map_row),
        .ready    (map_ready),
        .rd_member(rd_member),
        .rd_source(rd_source)
    );

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign in_x         = s_tdata[7:0];
    assign in_y         = s_tdata[15:8];
    assign hit          = pend_reg & rd_member & rd_source;
    assign outer_last   = from_low_reg ? (outer_reg == out_hi_reg) : (outer_reg == out_lo_reg);
    assign row_hit_edge = (y_reg == top_reg) || (y_reg == bottom_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            left_reg     <= '0;
            right_reg    <= '0;
            top_reg      <= '0;
            bottom_reg   <= '0;
            empty_reg    <= 1'b1;
            issuing_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            top_reg      <= top_next;
            bottom_reg   <= bottom_next;
            empty_reg    <= empty_next;
            issuing_reg  <= issuing_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        val_reg        <= val_next;
        inside_reg     <= inside_next;
        col_phase_reg  <= col_phase_next;
        from_low_reg   <= from_low_next;
        out_lo_reg     <= out_lo_next;
        out_hi_reg     <= out_hi_next;
        in_lo_reg      <= in_lo_next;
        in_hi_reg      <= in_hi_next;
        outer_reg      <= outer_next;
        inner_reg      <= inner_next;
        pend_outer_reg <= pend_outer_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        val_next        = val_reg;
        inside_next     = inside_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        top_next        = top_reg;
        bottom_next     = bottom_reg;
        empty_next      = empty_reg;
        col_phase_next  = col_phase_reg;
        from_low_next   = from_low_reg;
        out_lo_next     = out_lo_reg;
        out_hi_next     = out_hi_reg;
        in_lo_next      = in_lo_reg;
        in_hi_next      = in_hi_reg;
        outer_next      = outer_reg;
        inner_next      = inner_reg;
        issuing_next    = issuing_reg;
        pend_next       = pend_reg;
        pend_outer_next = pend_outer_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;
        map_req         = '0;
        map_col         = x_reg;
        map_row         = y_reg;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                if (map_ready) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                s_tready = ~m_tvalid_reg;
                if (s_tvalid && !m_tvalid_reg) begin
                    req_next    = req_t'(s_tuser);
                    x_next      = in_x;
                    y_next      = in_y;
                    val_next    = s_tdata[16];
                    inside_next = ({24'd0, in_x} < 32'(IMAGE_WIDTH)) &&
                                  ({24'd0, in_y} < 32'(IMAGE_HEIGHT));
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_FETCH;
                if (inside_reg) begin
                    unique case (req_reg)
                        REQ_WRITE: begin
                            map_req.src_we = 1'b1;
                            map_req.wr_bit = val_reg;
                        end
                        REQ_ADD: begin
                            map_req.mem_we = 1'b1;
                            map_req.wr_bit = 1'b1;
                            if (empty_reg) begin
                                empty_next  = 1'b0;
                                left_next   = x_reg;
                                right_next  = x_reg;
                                top_next    = y_reg;
                                bottom_next = y_reg;
                            end else begin
                                if (x_reg < left_reg) begin
                                    left_next = x_reg;
                                end else if (x_reg > right_reg) begin
                                    right_next = x_reg;
                                end
                                if (y_reg < top_reg) begin
                                    top_next = y_reg;
                                end else if (y_reg > bottom_reg) begin
                                    bottom_next = y_reg;
                                end
                            end
                        end
                        REQ_REMOVE: begin
                            map_req.mem_we = 1'b1;
                            map_req.wr_bit = 1'b0;
                            if (!empty_reg) begin
                                if (x_reg == left_reg || x_reg == right_reg) begin
                                    state_next = ST_COL_START;
                                end else if (row_hit_edge) begin
                                    state_next = ST_ROW_START;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_COL_START: begin
                col_phase_next = 1'b1;
                from_low_next  = (x_reg == left_reg);
                out_lo_next    = left_reg;
                out_hi_next    = right_reg;
                in_lo_next     = top_reg;
                in_hi_next     = bottom_reg;
                outer_next     = (x_reg == left_reg) ? left_reg : right_reg;
                inner_next     = top_reg;
                issuing_next   = 1'b1;
                pend_next      = 1'b0;
                state_next     = ST_SCAN;
            end

            ST_ROW_START: begin
                col_phase_next = 1'b0;
                from_low_next  = (y_reg == top_reg);
                out_lo_next    = top_reg;
                out_hi_next    = bottom_reg;
                in_lo_next     = left_reg;
                in_hi_next     = right_reg;
                outer_next     = (y_reg == top_reg) ? top_reg : bottom_reg;
                inner_next     = left_reg;
                issuing_next   = 1'b1;
                pend_next      = 1'b0;
                state_next     = ST_SCAN;
            end

            ST_SCAN: begin
                map_col = col_phase_reg ? outer_reg : inner_reg;
                map_row = col_phase_reg ? inner_reg : outer_reg;
                priority if (hit) begin
                    issuing_next = 1'b0;
                    pend_next    = 1'b0;
                    if (col_phase_reg) begin
                        if (from_low_reg) begin
                            left_next = pend_outer_reg;
                        end else begin
                            right_next = pend_outer_reg;
                        end
                        state_next = row_hit_edge ? ST_ROW_START : ST_FETCH;
                    end else begin
                        if (from_low_reg) begin
                            top_next = pend_outer_reg;
                        end else begin
                            bottom_next = pend_outer_reg;
                        end
                        state_next = ST_FETCH;
                    end
                end else if (!issuing_reg && !pend_reg) begin
                    empty_next  = 1'b1;
                    left_next   = '0;
                    right_next  = '0;
                    top_next    = '0;
                    bottom_next = '0;
                    state_next  = ST_FETCH;
                end else begin
                    pend_next = issuing_reg;
                    if (issuing_reg) begin
                        map_req.rd_en   = 1'b1;
                        pend_outer_next = outer_reg;
                        if (inner_reg == in_hi_reg) begin
                            inner_next = in_lo_reg;
                            if (outer_last) begin
                                issuing_next = 1'b0;
                            end else begin
                                outer_next = from_low_reg ? outer_reg + 1'b1
                                                          : outer_reg - 1'b1;
                            end
                        end else begin
                            inner_next = inner_reg + 1'b1;
                        end
                    end
                end
            end

            ST_FETCH: begin
                map_req.rd_en = inside_reg;
                state_next    = ST_RESULT;
            end

            ST_RESULT: begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {6'd0,
                                 inside_reg & rd_member & rd_source,
                                 empty_reg,
                                 empty_reg ? '0 : bottom_reg,
                                 empty_reg ? '0 : top_reg,
                                 empty_reg ? '0 : right_reg,
                                 empty_reg ? '0 : left_reg};
                state_next    = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: tb/region_mask_bounding_box_tracker_tb.sv
// Self-checking testbench for the region mask bounding box tracker.
`timescale 1ns / 1ps

module region_mask_bounding_box_tracker_tb;
    import rmbt_pkg::*;

    localparam int IMAGE_W = DEF_IMAGE_WIDTH;
    localparam int IMAGE_H = DEF_IMAGE_HEIGHT;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RANDOM_ITEMS = 130;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic   masked;
        logic   empty;
        coord_t bottom;
        coord_t top;
        coord_t right;
        coord_t left;
    } box_report_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    bit     member_bits [IMAGE_W*IMAGE_H];
    bit     source_bits [IMAGE_W*IMAGE_H];
    coord_t bound_left, bound_right, bound_top, bound_bottom;
    bit     region_is_empty = 1'b1;

    box_report_t expected_reports [$];
    int  mismatches = 0;
    int  reports_checked = 0;
    int  requests_sent = 0;
    int  removes_sent = 0;
    int  cycle_count = 0;
    bit  quiet = 1'b0;

    region_mask_bounding_box_tracker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic bit lit_pixel(int x, int y);
        if (x >= IMAGE_W || y >= IMAGE_H)
            return 1'b0;
        return member_bits[y*IMAGE_W + x] && source_bits[y*IMAGE_W + x];
    endfunction

    function automatic void rescan_edges(int x, int y);
        int  i, j, k, lo_x, hi_x, lo_y, hi_y;
        bit  found, from_first;
        found = 1'b1;
        lo_x = bound_left;
        hi_x = bound_right;
        lo_y = bound_top;
        hi_y = bound_bottom;
        if (x == lo_x || x == hi_x) begin
            from_first = (x == lo_x);
            found = 1'b0;
            for (k = 0; !found && k <= hi_x - lo_x; k++) begin
                i = from_first ? lo_x + k : hi_x - k;
                for (j = lo_y; j <= hi_y; j++) begin
                    if (lit_pixel(i, j)) begin
                        found = 1'b1;
                        break;
                    end
                end
            end
            if (found) begin
                if (from_first)
                    lo_x = i;
                else
                    hi_x = i;
            end
        end
        if (y == lo_y || y == hi_y) begin
            from_first = (y == lo_y);
            found = 1'b0;
            for (k = 0; !found && k <= hi_y - lo_y; k++) begin
                j = from_first ? lo_y + k : hi_y - k;
                for (i = lo_x; i <= hi_x; i++) begin
                    if (lit_pixel(i, j)) begin
                        found = 1'b1;
                        break;
                    end
                end
            end
            if (found) begin
                if (from_first)
                    lo_y = j;
                else
                    hi_y = j;
            end
        end
        if (!found) begin
            region_is_empty = 1'b1;
            lo_x = 0;
            hi_x = 0;
            lo_y = 0;
            hi_y = 0;
        end
        bound_left   = coord_t'(lo_x);
        bound_right  = coord_t'(hi_x);
        bound_top    = coord_t'(lo_y);
        bound_bottom = coord_t'(hi_y);
    endfunction

    function automatic box_report_t predict_box_report(logic [1:0] req, coord_t x, coord_t y,
                                                       logic v);
        box_report_t r;
        int addr;
        addr = int'(y) * IMAGE_W + int'(x);
        if (int'(x) < IMAGE_W && int'(y) < IMAGE_H) begin
            case (req)
                REQ_WRITE: begin
                    source_bits[addr] = v;
                end
                REQ_ADD: begin
                    member_bits[addr] = 1'b1;
                    if (region_is_empty) begin
                        region_is_empty = 1'b0;
                        bound_left   = x;
                        bound_right  = x;
                        bound_top    = y;
                        bound_bottom = y;
                    end else begin
                        if (x < bound_left)
                            bound_left = x;
                        else if (x > bound_right)
                            bound_right = x;
                        if (y < bound_top)
                            bound_top = y;
                        else if (y > bound_bottom)
                            bound_bottom = y;
                    end
                end
                REQ_REMOVE: begin
                    member_bits[addr] = 1'b0;
                    if (!region_is_empty)
                        rescan_edges(int'(x), int'(y));
                end
                default: begin
                end
            endcase
        end
        r.left   = region_is_empty ? '0 : bound_left;
        r.right  = region_is_empty ? '0 : bound_right;
        r.top    = region_is_empty ? '0 : bound_top;
        r.bottom = region_is_empty ? '0 : bound_bottom;
        r.empty  = region_is_empty;
        r.masked = lit_pixel(int'(x), int'(y));
        return r;
    endfunction

    task automatic send_request(logic [1:0] req, int x, int y, logic v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, v, coord_t'(y), coord_t'(x)};
        do
            @(posedge aclk);
        while (!s_tready);
        expected_reports.push_back(predict_box_report(req, coord_t'(x), coord_t'(y), v));
        requests_sent++;
        if (req == REQ_REMOVE)
            removes_sent++;
    endtask

    initial begin : result_ready
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do
                @(posedge aclk);
            while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin : check_results
        box_report_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[33:0];
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: tdata %h", m_tdata);
            end else begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (got.left !== want.left || got.right !== want.right ||
                    got.top !== want.top || got.bottom !== want.bottom ||
                    got.empty !== want.empty || got.masked !== want.masked) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected box %0d..%0d x %0d..%0d ",
                                 want.left, want.right, want.top, want.bottom,
                                 "empty %0b masked %0b, ", want.empty, want.masked,
                                 "got box %0d..%0d x %0d..%0d ",
                                 got.left, got.right, got.top, got.bottom,
                                 "empty %0b masked %0b", got.empty, got.masked);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                     expected_reports.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_empty_region;
        send_request(REQ_REMOVE, 10, 10, 1'b1);
        send_request(REQ_UNKNOWN, 0, 0, 1'b1);
        send_request(REQ_UNKNOWN, 255, 255, 1'b0);
    endtask

    task automatic test_full_image_box;
        send_request(REQ_WRITE, 0, 0, 1'b1);
        send_request(REQ_WRITE, 255, 255, 1'b1);
        send_request(REQ_ADD, 0, 0, 1'b0);
        send_request(REQ_ADD, 255, 255, 1'b0);
        send_request(REQ_UNKNOWN, 255, 255, 1'b0);
        send_request(REQ_REMOVE, 0, 0, 1'b0);
        send_request(REQ_REMOVE, 255, 255, 1'b0);
    endtask

    task automatic test_stale_box;
        send_request(REQ_WRITE, 5, 5, 1'b1);
        send_request(REQ_ADD, 5, 5, 1'b0);
        send_request(REQ_ADD, 9, 9, 1'b1);
        send_request(REQ_WRITE, 7, 7, 1'b1);
        send_request(REQ_ADD, 7, 7, 1'b0);
        send_request(REQ_REMOVE, 5, 5, 1'b0);
        send_request(REQ_REMOVE, 8, 8, 1'b0);
        send_request(REQ_REMOVE, 9, 9, 1'b0);
        send_request(REQ_WRITE, 7, 7, 1'b0);
        send_request(REQ_REMOVE, 7, 7, 1'b0);
    endtask

    task automatic test_random_windows;
        int span, base_x, base_y, ops, n, kind, x, y, i, j;
        int lo_x, hi_x, lo_y, hi_y;
        while (requests_sent < RANDOM_ITEMS) begin
            quiet  = ($urandom_range(0, 3) == 0);
            span   = ($urandom_range(0, 4) == 0) ? 16 : 8;
            base_x = $urandom_range(0, IMAGE_W - span);
            base_y = $urandom_range(0, IMAGE_H - span);
            ops    = $urandom_range(6, 20);
            for (n = 0; n < ops; n++) begin
                kind = $urandom_range(0, 99);
                x = base_x + $urandom_range(0, span - 1);
                y = base_y + $urandom_range(0, span - 1);
                if (kind < 30) begin
                    send_request(REQ_WRITE, x, y, $urandom_range(0, 3) != 0);
                end else if (kind < 62) begin
                    send_request(REQ_ADD, x, y, 1'($urandom_range(0, 1)));
                end else if (kind < 95) begin
                    if (!region_is_empty && $urandom_range(0, 3) != 0) begin
                        x = $urandom_range(bound_left, bound_right);
                        y = $urandom_range(bound_top, bound_bottom);
                        case ($urandom_range(0, 3))
                            0: x = bound_left;
                            1: x = bound_right;
                            2: y = bound_top;
                            default: y = bound_bottom;
                        endcase
                    end
                    send_request(REQ_REMOVE, x, y, 1'($urandom_range(0, 1)));
                end else begin
                    send_request(REQ_UNKNOWN, x, y, 1'($urandom_range(0, 1)));
                end
            end
            // Darken every lit member in the box so that one edge removal empties the region.
            if (!region_is_empty) begin
                lo_x = bound_left;
                hi_x = bound_right;
                lo_y = bound_top;
                hi_y = bound_bottom;
                for (j = lo_y; j <= hi_y; j++)
                    for (i = lo_x; i <= hi_x; i++)
                        if (lit_pixel(i, j))
                            send_request(REQ_WRITE, i, j, 1'b0);
                send_request(REQ_REMOVE, lo_x, lo_y, 1'b0);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_region();
        test_full_image_box();
        test_stale_box();
        test_random_windows();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("Sent %0d requests, %0d of them removes, and checked %0d result transactions.",
                 requests_sent, removes_sent, reports_checked);
        $display("Covered an empty region, a full-image box, stale members and random windows.");
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results missing.", mismatches,
                     expected_reports.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/rmbt_pkg.sv
rtl/rmbt_pixel_maps.sv
rtl/region_mask_bounding_box_tracker.sv
tb/region_mask_bounding_box_tracker_tb.sv
